/* src/skf_pkg.sv */
// Shared constants for the scalar Kalman filter: widths, register indexes and reset values.
package skf_pkg;

  localparam int DATA_W      = 32;
  localparam int MUL_W       = DATA_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VARIANCE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OBSERVATION_NOISE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN_SQUARED = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE_STEP = 3'd5;

  localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd134217728;
  localparam logic [DATA_W-1:0] RST_INITIAL_VARIANCE   = 32'd429497;
  localparam logic [DATA_W-1:0] RST_OBSERVATION_NOISE  = 32'd42949673;
  localparam logic [DATA_W-1:0] RST_DECAY_GAIN         = 32'd4168033832;
  localparam logic [DATA_W-1:0] RST_DECAY_GAIN_SQUARED = 32'd4044849875;
  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE_STEP = 32'd442642;

endpackage

/* src/scalar_kalman_filter_top.sv */
// Top level of the scalar Kalman filter: configuration registers, sequencer and state update.
//
// This block runs a one-dimensional Kalman filter over a stream of signed Q4.28 observation
// samples and returns, for every sample, the corrected estimate (signed Q4.28), the corrected
// variance and the gain used (both unsigned Q0.32). It works on one sample at a time. After a
// sample transaction is accepted the gain division runs in a bit-serial restoring divider,
// one quotient bit per cycle (skipped when the observation noise is zero); then two
// bit-serial multipliers form the estimate and variance corrections in parallel, one
// multiplier bit per cycle. Once the output register is free the result is placed in it and
// the same two multipliers propagate the state with the decay factors. The time per sample
// is set by the 32-step divider and the two 33-step multiplier passes, and the result
// transaction is offered before the propagation pass. The output register holds a result
// until it is taken, so the next sample can be accepted while the previous result still
// waits. Configuration registers should only be written while the block is idle; a write to
// initial_estimate or initial_variance takes effect at the next sample that carries restart.
module scalar_kalman_filter_top (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]      cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [skf_pkg::DATA_W-1:0] observation,
  input  logic                            restart,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [skf_pkg::DATA_W-1:0] filtered_estimate,
  output logic [skf_pkg::DATA_W-1:0]      posterior_variance,
  output logic [skf_pkg::DATA_W-1:0]      kalman_gain
);

  localparam int DW = skf_pkg::DATA_W;
  localparam int MW = skf_pkg::MUL_W;
  localparam int PW = skf_pkg::PROD_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_DIV      = 3'd2;
  localparam logic [2:0] ST_MULSTART = 3'd3;
  localparam logic [2:0] ST_CORRECT  = 3'd4;
  localparam logic [2:0] ST_POST     = 3'd5;
  localparam logic [2:0] ST_PROP     = 3'd6;

  localparam logic signed [DW+3:0] EST_MAX = 36'sd2147483647;
  localparam logic signed [DW+3:0] EST_MIN = -36'sd2147483648;

  // Round a Q0.32-scaled product to nearest, ties away from zero on the magnitude.
  function automatic logic [DW+1:0] round_q32(input logic [PW-1:0] p);
    round_q32 = p[PW-1:DW] + {{(DW+1){1'b0}}, p[DW-1]};
  endfunction

  // Apply a sign to a rounded magnitude, add a base estimate and clamp to 32 bits signed.
  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] base, input logic neg,
                                            input logic [DW+1:0] mag);
    logic signed [DW+3:0] term;
    logic signed [DW+3:0] sum;
    term = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum  = $signed({{4{base[DW-1]}}, base}) + term;
    if (sum > EST_MAX) begin
      sat_add = EST_MAX[DW-1:0];
    end else if (sum < EST_MIN) begin
      sat_add = EST_MIN[DW-1:0];
    end else begin
      sat_add = sum[DW-1:0];
    end
  endfunction

  // Configuration registers.
  logic [DW-1:0] initial_estimate;
  logic [DW-1:0] initial_variance;
  logic [DW-1:0] observation_noise;
  logic [DW-1:0] decay_gain;
  logic [DW-1:0] decay_gain_squared;
  logic [DW-1:0] process_noise_step;

  // Filter state and per-sample working registers.
  logic [DW-1:0] predicted_estimate;
  logic [DW-1:0] predicted_variance;
  logic [2:0]    state;
  logic [DW-1:0] est;
  logic [DW-1:0] p;
  logic [DW-1:0] obs;
  logic [DW-1:0] gain;
  logic          innov_neg;
  logic [MW-1:0] innov_mag;
  logic [DW-1:0] epost;
  logic [DW-1:0] vpost;

  // Multiplier and divider hookup.
  logic          mul_start;
  logic [MW-1:0] mul_a0, mul_b0, mul_a1, mul_b1;
  logic          mul_done0, mul_done1;
  logic [PW-1:0] prod0, prod1;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] quotient;

  // Combinational helpers.
  logic [DW:0]   innov;
  logic [DW:0]   denom;
  logic          out_free;
  logic [MW-1:0] epost_mag;
  logic [DW+1:0] vnext_round;
  logic [DW+1:0] vnext_sum;

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign innov     = {obs[DW-1], obs} - {est[DW-1], est};
  assign denom     = {1'b0, p} + {1'b0, observation_noise};
  assign epost_mag = epost[DW-1] ? (MW'(0) - {1'b1, epost}) : {1'b0, epost};
  assign vnext_round = round_q32(prod1);
  assign vnext_sum   = vnext_round + {2'b00, process_noise_step};

  // Both multipliers start together: correction pass in ST_MULSTART, propagation in ST_POST.
  assign mul_start = (state == ST_MULSTART) || ((state == ST_POST) && out_free);
  assign div_start = (state == ST_START) && (observation_noise != '0);

  always_comb begin
    if (state == ST_POST) begin
      mul_a0 = epost_mag;
      mul_b0 = {1'b0, decay_gain};
      mul_a1 = {1'b0, vpost};
      mul_b1 = {1'b0, decay_gain_squared};
    end else begin
      mul_a0 = innov_mag;
      mul_b0 = {1'b0, gain};
      mul_a1 = {1'b0, p};
      // One minus the gain, as an unsigned 33-bit Q1.32 factor.
      mul_b1 = {1'b1, {DW{1'b0}}} - {1'b0, gain};
    end
  end

  skf_serial_mul #(.WA(MW), .WB(MW)) u_mul0 (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a0),
    .b       (mul_b0),
    .done    (mul_done0),
    .product (prod0)
  );

  skf_serial_mul #(.WA(MW), .WB(MW)) u_mul1 (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a1),
    .b       (mul_b1),
    .done    (mul_done1),
    .product (prod1)
  );

  skf_serial_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (p),
    .denom    (denom),
    .done     (div_done),
    .quotient (quotient)
  );

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_estimate   <= skf_pkg::RST_INITIAL_ESTIMATE;
      initial_variance   <= skf_pkg::RST_INITIAL_VARIANCE;
      observation_noise  <= skf_pkg::RST_OBSERVATION_NOISE;
      decay_gain         <= skf_pkg::RST_DECAY_GAIN;
      decay_gain_squared <= skf_pkg::RST_DECAY_GAIN_SQUARED;
      process_noise_step <= skf_pkg::RST_PROCESS_NOISE_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::REG_INITIAL_ESTIMATE:   initial_estimate   <= cfg_data;
        skf_pkg::REG_INITIAL_VARIANCE:   initial_variance   <= cfg_data;
        skf_pkg::REG_OBSERVATION_NOISE:  observation_noise  <= cfg_data;
        skf_pkg::REG_DECAY_GAIN:         decay_gain         <= cfg_data;
        skf_pkg::REG_DECAY_GAIN_SQUARED: decay_gain_squared <= cfg_data;
        skf_pkg::REG_PROCESS_NOISE_STEP: process_noise_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, state update and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      predicted_estimate <= skf_pkg::RST_INITIAL_ESTIMATE;
      predicted_variance <= skf_pkg::RST_INITIAL_VARIANCE;
    end else begin
      // A new result may replace one that is taken at the same edge.
      if ((state == ST_POST) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            est   <= restart ? initial_estimate : predicted_estimate;
            p     <= restart ? initial_variance : predicted_variance;
            obs   <= observation;
            state <= ST_START;
          end
        end
        ST_START: begin
          innov_neg <= innov[DW];
          innov_mag <= innov[DW] ? (MW'(0) - innov) : innov;
          if (observation_noise == '0) begin
            // With no observation noise the gain is one, clamped, or zero for zero variance.
            gain  <= (p != '0) ? {DW{1'b1}} : '0;
            state <= ST_MULSTART;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            gain  <= quotient;
            state <= ST_MULSTART;
          end
        end
        ST_MULSTART: begin
          state <= ST_CORRECT;
        end
        ST_CORRECT: begin
          if (mul_done0) begin
            epost <= sat_add(est, innov_neg, round_q32(prod0));
            vpost <= prod1[PW-3:DW] + {{(DW-1){1'b0}}, prod1[DW-1]};
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (out_free) begin
            filtered_estimate  <= epost;
            posterior_variance <= vpost;
            kalman_gain        <= gain;
            state              <= ST_PROP;
          end
        end
        ST_PROP: begin
          if (mul_done1) begin
            predicted_estimate <= sat_add('0, epost[DW-1], round_q32(prod0));
            predicted_variance <= vnext_sum[DW+1:DW] != 2'b00 ? {DW{1'b1}} : vnext_sum[DW-1:0];
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/skf_serial_mul.sv */
// Serial-parallel unsigned multiplier that retires one multiplier bit per cycle.
module skf_serial_mul #(
  parameter int WA = skf_pkg::MUL_W,
  parameter int WB = skf_pkg::MUL_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             done,
  output logic [WA+WB-1:0] product
);

  localparam int CNT_W = $clog2(WB + 1);

  logic [WA-1:0]    a_reg;
  logic [WA-1:0]    hi;
  logic [WB-1:0]    lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [WA:0]      sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : {(WA+1){1'b0}});
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(WB);
        a_reg <= a;
        hi    <= '0;
        lo    <= b;
      end else if (busy) begin
        hi  <= sum[WA:1];
        lo  <= {sum[0], lo[WB-1:1]};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/skf_serial_div.sv */
// Restoring divider for the gain: floor(numer * 2^W / denom), one quotient bit per cycle.
module skf_serial_div #(
  parameter int W = skf_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] numer,
  input  logic [W:0]   denom,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  // The caller guarantees numer < denom, so the remainder always fits W+1 bits.
  logic [W:0]       rem;
  logic [W:0]       den_reg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W+1:0]     shifted;
  logic [W+1:0]     diff;
  logic             fits;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den_reg};
  assign fits    = shifted >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(W);
        rem      <= {1'b0, numer};
        den_reg  <= denom;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? diff[W:0] : shifted[W:0];
        quotient <= {quotient[W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the scalar Kalman filter top level.
`timescale 1ns / 100ps

module testbench;

  localparam int DATA_W      = skf_pkg::DATA_W;
  localparam int CFG_INDEX_W = skf_pkg::CFG_INDEX_W;

  // Timing of the run. The settle time covers the state propagation that the block still
  // performs after it has offered a result, so configuration writes never land mid-update.
  localparam int SETTLE_CYCLES   = 200;
  localparam int LONG_HOLD       = 600;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int N_PHASES        = 8;
  localparam int PHASE_SAMPLES   = 125;
  localparam int MAX_PRINTED     = 100;
  localparam int N_DIRECTED      = 31;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] NO_REG            = 3'd0;
  localparam int N_REGS = 6;

  localparam logic [DATA_W-1:0] RESET_VALUES [N_REGS] = '{
    skf_pkg::RST_INITIAL_ESTIMATE, skf_pkg::RST_INITIAL_VARIANCE,
    skf_pkg::RST_OBSERVATION_NOISE, skf_pkg::RST_DECAY_GAIN,
    skf_pkg::RST_DECAY_GAIN_SQUARED, skf_pkg::RST_PROCESS_NOISE_STEP
  };

  // One result transaction: corrected estimate, corrected variance and the gain used.
  typedef struct packed {
    logic [DATA_W-1:0] est;
    logic [DATA_W-1:0] pvar;
    logic [DATA_W-1:0] gain;
  } kf_result_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  // A directed row is either a register write or a sample. Sample rows with fixed set carry
  // an expected result that is typed in; all other samples are checked against the predictor.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  index;
    logic [DATA_W-1:0]       value;
    logic                    restart;
    logic                    fixed;
    kf_result_t              want;
  } dir_row_t;

  // The directed part walks the corner cases of the filter:
  //  - a sample straight after reset with the reset configuration;
  //  - zero observation noise with a nonzero variance, where the gain of exactly one
  //    saturates to all ones and the filtered estimate follows the observation;
  //  - propagated variance overflow, forced by a full-scale process noise step;
  //  - zero variance together with zero observation noise, where the gain is zero;
  //  - decay gains at zero and at full scale, estimates at both signed extremes;
  //  - writes to unmapped register indexes, which must change nothing;
  //  - a restart with the largest initial variance.
  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ROW_SMP, NO_REG, 32'h0800_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_OBSERVATION_NOISE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_VARIANCE, 32'h0010_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_ESTIMATE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_PROCESS_NOISE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h0000_0000, 1'b1, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{ROW_SMP, NO_REG, 32'h1000_0000, 1'b0, 1'b1,
      '{32'h1000_0000, 32'h0000_0001, 32'hFFFF_FFFF}},
    '{ROW_SMP, NO_REG, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_VARIANCE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_ESTIMATE, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_PROCESS_NOISE_STEP, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_DECAY_GAIN, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h7FFF_FFFF, 1'b1, 1'b1,
      '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000}},
    '{ROW_SMP, NO_REG, 32'h7FFF_FFFF, 1'b0, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    '{ROW_CFG, skf_pkg::REG_DECAY_GAIN, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_DECAY_GAIN_SQUARED, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h8000_0000, 1'b1, 1'b1,
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000}},
    '{ROW_SMP, NO_REG, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_UNMAPPED_LOW, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_UNMAPPED_HIGH, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_OBSERVATION_NOISE, skf_pkg::RST_OBSERVATION_NOISE,
      1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_DECAY_GAIN, skf_pkg::RST_DECAY_GAIN, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_DECAY_GAIN_SQUARED, skf_pkg::RST_DECAY_GAIN_SQUARED,
      1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_VARIANCE, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_INITIAL_ESTIMATE, skf_pkg::RST_INITIAL_ESTIMATE,
      1'b0, 1'b0, '0},
    '{ROW_CFG, skf_pkg::REG_PROCESS_NOISE_STEP, skf_pkg::RST_PROCESS_NOISE_STEP,
      1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h0800_0000, 1'b1, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'hF000_0000, 1'b0, 1'b0, '0},
    '{ROW_SMP, NO_REG, 32'h0000_0001, 1'b0, 1'b0, '0}
  };

  // Every input of the block starts at a known value.
  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
  logic [DATA_W-1:0]          cfg_data    = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic signed [DATA_W-1:0]   observation = '0;
  logic                       restart     = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic signed [DATA_W-1:0]   filtered_estimate;
  logic [DATA_W-1:0]          posterior_variance;
  logic [DATA_W-1:0]          kalman_gain;

  // The typed expectation travels with the sample payload, so it is sampled at the same
  // edge as the sample transaction itself.
  logic                       drive_fixed  = 1'b0;
  kf_result_t                 drive_want   = '0;

  scalar_kalman_filter_top dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .observation        (observation),
    .restart            (restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .filtered_estimate  (filtered_estimate),
    .posterior_variance (posterior_variance),
    .kalman_gain        (kalman_gain)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copies of the configuration registers and of the filter state.
  logic [DATA_W-1:0] cfg_shadow [N_REGS] = RESET_VALUES;
  logic [DATA_W-1:0] est_state = skf_pkg::RST_INITIAL_ESTIMATE;
  logic [DATA_W-1:0] var_state = skf_pkg::RST_INITIAL_VARIANCE;

  kf_result_t expected_results [$];
  int mismatches   = 0;
  int burst_left   = 0;
  bit hold_request = 1'b0;

  // Multiplies a signed value by an unsigned Q0.32 factor and rounds the magnitude to
  // nearest, with ties going away from zero.
  function automatic logic signed [65:0] round_scale(input logic signed [65:0] s,
                                                     input logic [65:0] f);
    logic [65:0] mag;
    logic [65:0] r;
    mag = (s < 0) ? -s : s;
    r = (mag * f + 66'h8000_0000) >> 32;
    return (s < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q428(input logic signed [65:0] v);
    if (v > 66'sd2147483647)
      return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648)
      return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Runs one filter update on the shadow state and returns the result it must produce.
  function automatic kf_result_t filter_step(input logic [DATA_W-1:0] obs, input logic rs);
    logic signed [65:0] est;
    logic signed [65:0] innov;
    logic signed [65:0] epost;
    logic [65:0] p;
    logic [65:0] denom;
    logic [65:0] gain;
    logic [65:0] vpost;
    logic [65:0] vnext;
    kf_result_t res;
    if (rs) begin
      est_state = cfg_shadow[skf_pkg::REG_INITIAL_ESTIMATE];
      var_state = cfg_shadow[skf_pkg::REG_INITIAL_VARIANCE];
    end
    est = $signed(est_state);
    p = var_state;
    innov = $signed(obs) - est;
    denom = p + cfg_shadow[skf_pkg::REG_OBSERVATION_NOISE];
    if (denom == 0) begin
      gain = '0;
    end else begin
      gain = (p << 32) / denom;
      if (gain > 66'hFFFF_FFFF)
        gain = 66'hFFFF_FFFF;
    end
    epost = clamp_q428(est + round_scale(innov, gain));
    vpost = ((p << 32) - p * gain + 66'h8000_0000) >> 32;
    res.est  = epost[31:0];
    res.pvar = vpost[31:0];
    res.gain = gain[31:0];
    vnext = ((vpost * cfg_shadow[skf_pkg::REG_DECAY_GAIN_SQUARED] + 66'h8000_0000) >> 32)
            + cfg_shadow[skf_pkg::REG_PROCESS_NOISE_STEP];
    if (vnext > 66'hFFFF_FFFF)
      vnext = 66'hFFFF_FFFF;
    est_state = clamp_q428(round_scale(epost, cfg_shadow[skf_pkg::REG_DECAY_GAIN]));
    var_state = vnext[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", field, got, want));
  endtask

  // Result side first: a result accepted at the same edge as a sample always belongs to an
  // older sample, so the new expectation must not be visible to it.
  always @(posedge clk) begin : result_checker
    kf_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, estimate %h",
                                    filtered_estimate));
        end else begin
          want = expected_results.pop_front();
          check_field("filtered_estimate", filtered_estimate, want.est);
          check_field("posterior_variance", posterior_variance, want.pvar);
          check_field("kalman_gain", kalman_gain, want.gain);
        end
      end
      if (in_valid && in_ready) begin
        want = filter_step(observation, restart);
        if (drive_fixed)
          want = drive_want;
        expected_results = {expected_results, want};
      end
    end
  end

  // The watchdog ends a run that has stopped moving: any accepted transaction on either
  // channel clears the count of quiet cycles.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The receiver walks through stretches of different stall patterns: always ready, coin
  // flips, mostly stalled, and a rotating mask. On request it holds off for a long stretch,
  // which fills the output register and the block behind it so that the input stalls too.
  initial begin : receiver
    int mode;
    int stretch;
    int hold;
    logic [7:0] stall_mask;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(10, 200);
      stall_mask = 8'($urandom);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          hold = LONG_HOLD;
        end
        stall_mask = {stall_mask[6:0], stall_mask[7]};
        if (hold > 0) begin
          hold--;
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_mask[0];
          endcase
        end
      end
    end
  end

  // A register write holds the enable high for exactly one cycle. The
  // shadow copy is updated at once, which is safe because writes happen only while idle.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx < N_REGS)
      cfg_shadow[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one sample transaction and returns at the edge where it is accepted. The sender
  // works in bursts; between bursts it drops valid for a random number of cycles, so that
  // new samples arrive at every point of the block's divide and multiply passes.
  task automatic send_sample(input logic [DATA_W-1:0] obs, input logic rs,
                             input logic fixed, input kf_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 130);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid    <= 1'b1;
    observation <= obs;
    restart     <= rs;
    drive_fixed <= fixed;
    drive_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering samples until every expected result has arrived, then lets the block
  // finish its trailing state propagation.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random register values: reset values, both extremes, and realistic spreads. Decay
  // factors mostly stay close to one, variances and noise span many magnitudes.
  function automatic logic [DATA_W-1:0] pick_setting(input int idx);
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = RESET_VALUES[idx];
      1: v = '0;
      2: v = '1;
      default: begin
        if (idx == skf_pkg::REG_DECAY_GAIN || idx == skf_pkg::REG_DECAY_GAIN_SQUARED)
          v = 32'hE000_0000 | $urandom;
        else if (idx == skf_pkg::REG_INITIAL_ESTIMATE)
          v = $signed($urandom) >>> $urandom_range(0, 6);
        else
          v = $urandom >> $urandom_range(0, 28);
      end
    endcase
    return v;
  endfunction

  // Random observations: mostly moderate values of either sign, some full-range words and
  // some signed extremes.
  function automatic logic [DATA_W-1:0] pick_observation();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom) >>> $urandom_range(1, 8);
    endcase
  endfunction

  initial begin : stimulus
    bit settled;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    settled = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!settled)
          wait_idle();
        cfg_write(directed_rows[i].index, directed_rows[i].value);
        settled = 1'b1;
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].restart,
                    directed_rows[i].fixed, directed_rows[i].want);
        settled = 1'b0;
      end
    end

    // Random phases. The first restores the reset configuration; later ones draw a new
    // setting for each register. Every phase pause doubles as the point where the sender
    // waits for every outstanding result, and one phase opens with a long receiver hold.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      for (int r = 0; r < N_REGS; r++)
        cfg_write(r[CFG_INDEX_W-1:0], (phase == 0) ? RESET_VALUES[r] : pick_setting(r));
      if ($urandom_range(0, 2) == 0)
        cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_LOW : REG_UNMAPPED_HIGH, $urandom);
      if (phase == 3)
        hold_request = 1'b1;
      for (int n = 0; n < PHASE_SAMPLES; n++)
        send_sample(pick_observation(), ($urandom_range(0, 19) == 0) || (n == 0), 1'b0, '0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* scalar_kalman_filter_top.f */
src/skf_pkg.sv
src/skf_serial_mul.sv
src/skf_serial_div.sv
src/scalar_kalman_filter_top.sv
sim/testbench.sv
